@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/bcpm_pkg.sv @@
// Package with constants, types and helpers for the paged memory
`default_nettype none
package bcpm_pkg;

  localparam int unsigned PAGE_BYTES     = 65536;
  localparam int unsigned HARD_MAX_PAGES = 1;
  localparam longint unsigned STORE_BYTES =
    64'(PAGE_BYTES) * 64'(HARD_MAX_PAGES);

  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int ROW_BYTES     = 16;
  localparam int ROW_W         = ADDR_W - 4;
  localparam int ROWS          = int'(STORE_BYTES / ROW_BYTES);
  localparam int ROWS_PER_PAGE = PAGE_BYTES / ROW_BYTES;
  localparam int PAGES_W       = 17;
  localparam int PROD_W        = PAGES_W + ROW_W;
  localparam int LIMIT_W       = 34;
  localparam int PADDR_W       = 4;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;
  localparam logic [1:0] REQ_GROW  = 2'd2;

  localparam logic [1:0] REG_INITIAL_PAGES = 2'd0;
  localparam logic [1:0] REG_HAS_MAX_LIMIT = 2'd1;
  localparam logic [1:0] REG_MAX_PAGES     = 2'd2;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic              en;
    logic              wr;
    logic              clr;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        size;
    logic [63:0]       wdata;
  } mem_req_t;

  function automatic logic [7:0] lane_mask(input logic [1:0] size);
    logic [7:0] m;
    case (size)
      2'd0:    m = 8'h01;
      2'd1:    m = 8'h03;
      2'd2:    m = 8'h0F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [1:0] size);
    logic [7:0]  l;
    logic [63:0] m;
    l = lane_mask(size);
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = {8{l[i]}};
    end
    return m;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bcpm_store.sv @@
// Two banked byte-enable memories with unaligned access steering
`default_nettype none
module bcpm_store (
  input  wire logic                clk,
  input  wire bcpm_pkg::mem_req_t  req,
  output logic [63:0]              rdata
);
  import bcpm_pkg::*;

  logic [63:0] even_mem [ROWS];
  logic [63:0] odd_mem  [ROWS];

  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_inc;
  logic             w_odd;
  logic [2:0]       off;
  logic [15:0]      be16;
  logic [127:0]     data128;
  logic [ROW_W-1:0] even_row;
  logic [ROW_W-1:0] odd_row;
  logic [7:0]       even_be;
  logic [7:0]       odd_be;
  logic [63:0]      even_wd;
  logic [63:0]      odd_wd;
  logic             we;

  logic [63:0] even_q;
  logic [63:0] odd_q;
  logic        odd_sel;
  logic [2:0]  off_q;
  logic [1:0]  size_q;

  logic [63:0]  lo;
  logic [63:0]  hi;
  logic [127:0] shifted;

  always_comb begin
    row     = req.addr[ADDR_W-1:4];
    row_inc = row + ROW_W'(1);
    w_odd   = req.addr[3];
    off     = req.addr[2:0];
    be16    = {8'h00, lane_mask(req.size)} << off;
    data128 = {64'h0, req.wdata} << {off, 3'b000};
    we      = req.en && (req.wr || req.clr);
    if (req.clr) begin
      even_row = row;
      odd_row  = row;
      even_be  = 8'hFF;
      odd_be   = 8'hFF;
      even_wd  = 64'h0;
      odd_wd   = 64'h0;
    end else if (w_odd) begin
      even_row = row_inc;
      odd_row  = row;
      even_be  = be16[15:8];
      odd_be   = be16[7:0];
      even_wd  = data128[127:64];
      odd_wd   = data128[63:0];
    end else begin
      even_row = row;
      odd_row  = row;
      even_be  = be16[7:0];
      odd_be   = be16[15:8];
      even_wd  = data128[63:0];
      odd_wd   = data128[127:64];
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (we) begin
        for (int i = 0; i < 8; i++) begin
          if (even_be[i]) begin
            even_mem[even_row][8*i +: 8] <= even_wd[8*i +: 8];
          end
        end
      end
      even_q <= even_mem[even_row];
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (we) begin
        for (int i = 0; i < 8; i++) begin
          if (odd_be[i]) begin
            odd_mem[odd_row][8*i +: 8] <= odd_wd[8*i +: 8];
          end
        end
      end
      odd_q <= odd_mem[odd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      odd_sel <= w_odd;
      off_q   <= off;
      size_q  <= req.size;
    end
  end

  always_comb begin
    lo      = odd_sel ? odd_q : even_q;
    hi      = odd_sel ? even_q : odd_q;
    shifted = {hi, lo} >> {off_q, 3'b000};
    rdata   = shifted[63:0] & byte_mask(size_q);
  end

endmodule
`default_nettype wire

@@ hw/rtl/bounds_checked_paged_memory.sv @@
// Top level of the bounds-checked paged linear memory
//
// Requests enter on start with req_type, address, size_code, store_data and
// grow_delta; one is taken at each rising edge where start is high and busy
// is low. Every request yields one result in the next cycle: done pulses for
// a single cycle with load_data, status and grow_result valid. The receiver
// cannot stall, so results are never held back.
// Loads and stores may be issued every cycle while busy is low; the
// byte store lives in two single-port banks of 64-bit rows, which lets an
// unaligned 8-byte access complete in one read or write.
// Out-of-bounds accesses report status 1 and change nothing.
// After reset, and after a grow from zero pages, busy stays high for a
// clearing pass that zeroes one 16-byte row per cycle through the bank
// port, over the full store after reset. Configuration writes over the
// APB port take effect at the access edge; issue them only while no
// transaction is in flight.
// Reset zeroes the store, restores the registers and sets the pages in use
// to the initial page count.
`default_nettype none
module bounds_checked_paged_memory (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   req_type,
  input  wire logic [31:0]                  address,
  input  wire logic [1:0]                   size_code,
  input  wire logic [63:0]                  store_data,
  input  wire logic [31:0]                  grow_delta,
  output logic                              done,
  output logic [63:0]                       load_data,
  output logic                              status,
  output logic signed [17:0]                grow_result,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bcpm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import bcpm_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [ROW_W-1:0] clr_row;
  logic [ROW_W-1:0] clr_row_next;
  logic [ROW_W-1:0] clr_last;
  logic [ROW_W-1:0] clr_last_next;

  logic [PAGES_W-1:0] initial_pages;
  logic               has_max_limit;
  logic [PAGES_W-1:0] page_ceiling;
  logic [PAGES_W-1:0] pages;

  logic               accept;
  logic               cfg_wr;
  logic [32:0]        end_addr;
  logic [LIMIT_W-1:0] limit;
  logic               oob;
  logic               is_access;
  logic               is_grow;
  logic [32:0]        grown;
  logic               grow_fail;
  logic               grow_take;
  logic [PROD_W-1:0]  start_prod;
  logic [PROD_W-1:0]  end_prod;
  logic [PAGES_W-1:0] cfg_pages;

  mem_req_t    mem_req;
  logic [63:0] mem_rdata;

  logic               load_ok;
  logic signed [17:0] grow_q;

  assign pready = 1'b1;
  assign busy   = (state == ST_CLEAR);
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    is_access  = (req_type == REQ_LOAD) || (req_type == REQ_STORE);
    is_grow    = (req_type == REQ_GROW);
    end_addr   = {1'b0, address} + (33'd1 << size_code);
    limit      = LIMIT_W'(pages) * LIMIT_W'(PAGE_BYTES);
    oob        = (LIMIT_W'(end_addr) > limit) ||
                 (LIMIT_W'(end_addr) > LIMIT_W'(STORE_BYTES));
    grown      = 33'(pages) + 33'(grow_delta);
    grow_fail  = (grown > 33'(HARD_MAX_PAGES)) ||
                 (has_max_limit && (grown > 33'(page_ceiling)));
    grow_take  = accept && is_grow && (grow_delta != 32'd0) && !grow_fail;
    start_prod = PROD_W'(pages) * PROD_W'(ROWS_PER_PAGE);
    end_prod   = PROD_W'(grown[PAGES_W-1:0]) * PROD_W'(ROWS_PER_PAGE) - PROD_W'(1);
    cfg_pages  = (pwdata[PAGES_W-1:0] > PAGES_W'(HARD_MAX_PAGES)) ?
                 PAGES_W'(HARD_MAX_PAGES) : pwdata[PAGES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_row  <= '0;
      clr_last <= ROW_W'(ROWS - 1);
    end else begin
      state    <= state_next;
      clr_row  <= clr_row_next;
      clr_last <= clr_last_next;
    end
  end

  always_comb begin
    state_next    = state;
    clr_row_next  = clr_row;
    clr_last_next = clr_last;
    mem_req       = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_req.en   = 1'b1;
        mem_req.clr  = 1'b1;
        mem_req.addr = {clr_row, 4'b0000};
        clr_row_next = clr_row + ROW_W'(1);
        if (clr_row == clr_last) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        mem_req.en    = accept && is_access && !oob;
        mem_req.wr    = (req_type == REQ_STORE);
        mem_req.addr  = ADDR_W'(address);
        mem_req.size  = size_code;
        mem_req.wdata = store_data;
        if (grow_take) begin
          state_next    = ST_CLEAR;
          clr_row_next  = ROW_W'(start_prod);
          clr_last_next = ROW_W'(end_prod);
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_pages <= PAGES_W'(1);
      has_max_limit <= 1'b0;
      page_ceiling  <= PAGES_W'(65536);
      pages         <= PAGES_W'(1) > PAGES_W'(HARD_MAX_PAGES) ?
                       PAGES_W'(HARD_MAX_PAGES) : PAGES_W'(1);
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_INITIAL_PAGES: begin
            initial_pages <= pwdata[PAGES_W-1:0];
            pages         <= cfg_pages;
          end
          REG_HAS_MAX_LIMIT: has_max_limit <= pwdata[0];
          REG_MAX_PAGES:     page_ceiling  <= pwdata[PAGES_W-1:0];
          default: ;
        endcase
      end else if (grow_take) begin
        pages <= grown[PAGES_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_INITIAL_PAGES: prdata = 32'(initial_pages);
      REG_HAS_MAX_LIMIT: prdata = 32'(has_max_limit);
      REG_MAX_PAGES:     prdata = 32'(page_ceiling);
      default:           prdata = 32'h0;
    endcase
  end

  bcpm_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      load_ok <= (req_type == REQ_LOAD) && !oob;
      status  <= is_access && oob;
      if (is_grow) begin
        grow_q <= (grow_delta != 32'd0 && grow_fail) ? 18'sh3FFFF :
                  $signed({1'b0, pages});
      end else begin
        grow_q <= 18'sd0;
      end
    end
  end

  assign load_data   = (done && load_ok) ? mem_rdata : 64'h0;
  assign grow_result = grow_q;

endmodule
`default_nettype wire

@@ hw/rtl/bcpm_checker.sv @@
// Port-level checker for the paged memory, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module bcpm_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic [1:0]         req_type,
  input wire logic               done,
  input wire logic [63:0]        load_data,
  input wire logic               status,
  input wire logic signed [17:0] grow_result
);
  import bcpm_pkg::*;

  `ASSERT_NEXT(a_result_follows, clk, rst, start && !busy, done)
  `ASSERT_NEXT(a_no_spurious_result, clk, rst, !(start && !busy), !done)
  `ASSERT_IMPLIES(a_trap_clean, clk, rst, done && status, load_data == 64'h0 && grow_result == 18'sd0)
  `ASSERT_IMPLIES(a_grow_clean, clk, rst, done && grow_result != 18'sd0, load_data == 64'h0 && !status)
  `ASSERT_IMPLIES(a_clear_after_grow, clk, rst, $rose(busy), $past(start) && $past(req_type) == REQ_GROW)

endmodule

bind bounds_checked_paged_memory bcpm_checker u_bcpm_checker (.*);
`default_nettype wire

@@ dv/bounds_checked_paged_memory_test.sv @@
// Self-checking testbench for the bounds-checked paged memory
`timescale 1ns / 1ps
module bounds_checked_paged_memory_test;
  import bcpm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 100;
  localparam int PHASES = 7;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [1:0]  size_code;
    logic [63:0] store_data;
    logic [31:0] grow_delta;
  } mem_request_t;

  typedef struct packed {
    logic [63:0] load_data;
    logic        status;
    logic [17:0] grow_result;
  } mem_response_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t     kind;
    mem_request_t  rq;
    bit            typed;
    mem_response_t want;
    logic [1:0]    reg_sel;
    logic [31:0]   reg_val;
  } directed_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         req_type;
  logic [31:0]        address;
  logic [1:0]         size_code;
  logic [63:0]        store_data;
  logic [31:0]        grow_delta;
  logic               done;
  logic [63:0]        load_data;
  logic               status;
  logic signed [17:0] grow_result;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  logic        cfg_has_max;
  logic [16:0] cfg_page_ceiling;
  logic [16:0] pages_now;
  logic [7:0]  mem_image [int'(STORE_BYTES)];

  mem_response_t pending_responses[$];
  directed_row_t directed_rows[$];

  int mismatches = 0;
  int responses_checked = 0;
  int stall_cycles = 0;
  int n_load = 0;
  int n_store = 0;
  int n_trap = 0;
  int n_grow = 0;
  int n_grow_refused = 0;
  int n_unused = 0;
  int n_settings = 0;

  bounds_checked_paged_memory dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .address    (address),
    .size_code  (size_code),
    .store_data (store_data),
    .grow_delta (grow_delta),
    .done       (done),
    .load_data  (load_data),
    .status     (status),
    .grow_result(grow_result),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic mem_response_t memory_response(input mem_request_t rq);
    mem_response_t    rsp;
    longint unsigned  span_end;
    longint unsigned  usable;
    longint unsigned  grown;
    longint unsigned  clear_to;
    int unsigned      nbytes;
    rsp = '0;
    nbytes = 1 << rq.size_code;
    usable = 64'(pages_now) * 64'(PAGE_BYTES);
    if (rq.req_type == REQ_LOAD || rq.req_type == REQ_STORE) begin
      span_end = 64'(rq.address) + 64'(nbytes);
      if (span_end > usable || span_end > STORE_BYTES) begin
        rsp.status = 1'b1;
      end else if (rq.req_type == REQ_LOAD) begin
        for (int i = 0; i < nbytes; i++) begin
          rsp.load_data[8*i +: 8] = mem_image[int'(rq.address) + i];
        end
      end else begin
        for (int i = 0; i < nbytes; i++) begin
          mem_image[int'(rq.address) + i] = rq.store_data[8*i +: 8];
        end
      end
    end else if (rq.req_type == REQ_GROW) begin
      grown = 64'(pages_now) + 64'(rq.grow_delta);
      if (rq.grow_delta == 32'd0) begin
        rsp.grow_result = 18'(pages_now);
      end else if (grown > 64'(HARD_MAX_PAGES) ||
                   (cfg_has_max && grown > 64'(cfg_page_ceiling))) begin
        rsp.grow_result = '1;
      end else begin
        clear_to = grown * 64'(PAGE_BYTES);
        if (clear_to > STORE_BYTES) clear_to = STORE_BYTES;
        for (longint unsigned b = usable; b < clear_to; b++) begin
          mem_image[int'(b)] = 8'h00;
        end
        rsp.grow_result = 18'(pages_now);
        pages_now = 17'(grown);
      end
    end
    return rsp;
  endfunction

  function automatic void add_req(input bit typed, input logic [1:0] rt,
                                  input logic [31:0] addr, input logic [1:0] sz,
                                  input logic [63:0] wdata, input logic [31:0] delta,
                                  input logic [63:0] ld, input logic st,
                                  input logic [17:0] gr);
    directed_row_t row;
    row.kind = ROW_REQ;
    row.rq = '{rt, addr, sz, wdata, delta};
    row.typed = typed;
    row.want = '{ld, st, gr};
    row.reg_sel = REG_INITIAL_PAGES;
    row.reg_val = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [1:0] sel, input logic [31:0] val);
    directed_row_t row;
    row.kind = ROW_CFG;
    row.rq = '0;
    row.typed = 1'b0;
    row.want = '0;
    row.reg_sel = sel;
    row.reg_val = val;
    directed_rows.push_back(row);
  endfunction

  task automatic issue(input mem_request_t rq, input bit typed,
                       input mem_response_t want);
    mem_response_t rsp;
    start <= 1'b1;
    req_type <= rq.req_type;
    address <= rq.address;
    size_code <= rq.size_code;
    store_data <= rq.store_data;
    grow_delta <= rq.grow_delta;
    @(posedge clk);
    while (busy) @(posedge clk);
    rsp = memory_response(rq);
    pending_responses.push_back(typed ? want : rsp);
    case (rq.req_type)
      REQ_LOAD:  n_load++;
      REQ_STORE: n_store++;
      REQ_GROW: begin
        n_grow++;
        if (rsp.grow_result == '1) n_grow_refused++;
      end
      default:   n_unused++;
    endcase
    if (rsp.status) n_trap++;
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_responses.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] sel, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (sel)
      REG_INITIAL_PAGES: begin
        pages_now = (val[16:0] > 17'(HARD_MAX_PAGES)) ? 17'(HARD_MAX_PAGES) : val[16:0];
      end
      REG_HAS_MAX_LIMIT: cfg_has_max = val[0];
      REG_MAX_PAGES:     cfg_page_ceiling = val[16:0];
      default: ;
    endcase
  endtask

  function automatic mem_request_t random_request();
    mem_request_t rq;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) rq.req_type = REQ_LOAD;
    else if (pick < 85) rq.req_type = REQ_STORE;
    else if (pick < 95) rq.req_type = REQ_GROW;
    else rq.req_type = REQ_UNUSED;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: rq.address = $urandom_range(0, 255);
      6, 7:             rq.address = $urandom_range(65520, 65535);
      8:                rq.address = $urandom_range(0, 65535);
      default:          rq.address = $urandom;
    endcase
    rq.size_code = 2'($urandom_range(0, 3));
    rq.store_data = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2: rq.grow_delta = 32'd0;
      3, 4, 5: rq.grow_delta = 32'd1;
      6:       rq.grow_delta = 32'd2;
      7:       rq.grow_delta = $urandom_range(0, 65536);
      8:       rq.grow_delta = $urandom;
      default: rq.grow_delta = '1;
    endcase
    return rq;
  endfunction

  always @(posedge clk) begin : check_responses
    mem_response_t want;
    if (!rst && done) begin
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected response: load_data=%h status=%b grow_result=%h",
                   load_data, status, grow_result);
        end
      end else begin
        want = pending_responses.pop_front();
        responses_checked++;
        if (load_data !== want.load_data || status !== want.status ||
            grow_result !== want.grow_result) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: load_data exp %h got %h, status exp %b got %b",
                     $realtime, want.load_data, load_data, want.status, status);
            $display("  grow_result exp %h got %h", want.grow_result, grow_result);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    mem_request_t rq;
    int burst_left;
    int pressure_at;
    bit quiet;
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_LOAD;
    address = '0;
    size_code = '0;
    store_data = '0;
    grow_delta = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < int'(STORE_BYTES); i++) mem_image[i] = 8'h00;
    cfg_has_max = 1'b0;
    cfg_page_ceiling = 17'd65536;
    pages_now = 17'd1;

    add_req(1'b1, REQ_LOAD, 32'd0, 2'd3, 64'd0, 32'd0, 64'd0, 1'b0, 18'd0);
    add_req(1'b1, REQ_LOAD, 32'd65528, 2'd3, 64'd0, 32'd0, 64'd0, 1'b0, 18'd0);
    add_req(1'b1, REQ_LOAD, 32'd65529, 2'd3, 64'd0, 32'd0, 64'd0, 1'b1, 18'd0);
    add_req(1'b1, REQ_STORE, 32'd65535, 2'd0, '1, '1, 64'd0, 1'b0, 18'd0);
    add_req(1'b1, REQ_LOAD, 32'd65535, 2'd0, 64'd0, 32'd0, 64'hFF, 1'b0, 18'd0);
    add_req(1'b1, REQ_STORE, 32'hFFFF_FFFF, 2'd3, '1, 32'd0, 64'd0, 1'b1, 18'd0);
    add_req(1'b1, REQ_STORE, 32'd0, 2'd3, '1, 32'd0, 64'd0, 1'b0, 18'd0);
    add_req(1'b0, REQ_STORE, 32'd3, 2'd2, 64'h0123_4567_89AB_CDEF, 32'd0, 64'd0, 1'b0,
            18'd0);
    add_req(1'b0, REQ_LOAD, 32'd1, 2'd3, 64'd0, 32'd0, 64'd0, 1'b0, 18'd0);
    add_req(1'b0, REQ_LOAD, 32'd5, 2'd1, 64'd0, 32'd0, 64'd0, 1'b0, 18'd0);
    add_req(1'b1, REQ_LOAD, 32'd65535, 2'd1, 64'd0, 32'd0, 64'd0, 1'b1, 18'd0);
    add_req(1'b1, REQ_LOAD, 32'h8000_0000, 2'd0, 64'd0, 32'd0, 64'd0, 1'b1, 18'd0);
    add_req(1'b1, REQ_GROW, 32'd0, 2'd0, 64'd0, 32'd0, 64'd0, 1'b0, 18'd1);
    add_req(1'b1, REQ_GROW, 32'd0, 2'd0, 64'd0, 32'd1, 64'd0, 1'b0, '1);
    add_req(1'b1, REQ_GROW, 32'd0, 2'd0, 64'd0, '1, 64'd0, 1'b0, '1);
    add_req(1'b1, REQ_UNUSED, '1, 2'd3, '1, '1, 64'd0, 1'b0, 18'd0);
    add_req(1'b0, REQ_STORE, 32'd100, 2'd3, 64'hA5A5_5A5A_C3C3_3C3C, 32'd0, 64'd0, 1'b0,
            18'd0);
    add_cfg(REG_INITIAL_PAGES, 32'd65536);
    add_req(1'b0, REQ_LOAD, 32'd100, 2'd3, 64'd0, 32'd0, 64'd0, 1'b0, 18'd0);
    add_cfg(REG_INITIAL_PAGES, 32'd0);
    add_req(1'b1, REQ_LOAD, 32'd0, 2'd0, 64'd0, 32'd0, 64'd0, 1'b1, 18'd0);
    add_req(1'b1, REQ_STORE, 32'd0, 2'd0, '1, 32'd0, 64'd0, 1'b1, 18'd0);
    add_req(1'b1, REQ_GROW, 32'd0, 2'd0, 64'd0, 32'd0, 64'd0, 1'b0, 18'd0);
    add_cfg(REG_HAS_MAX_LIMIT, 32'd1);
    add_cfg(REG_MAX_PAGES, 32'd0);
    add_req(1'b1, REQ_GROW, 32'd0, 2'd0, 64'd0, 32'd1, 64'd0, 1'b0, '1);
    add_cfg(REG_MAX_PAGES, 32'd1);
    add_req(1'b1, REQ_GROW, 32'd0, 2'd0, 64'd0, 32'd1, 64'd0, 1'b0, 18'd0);
    add_req(1'b1, REQ_LOAD, 32'd100, 2'd3, 64'd0, 32'd0, 64'd0, 1'b0, 18'd0);
    add_req(1'b1, REQ_GROW, 32'd0, 2'd0, 64'd0, 32'd1, 64'd0, 1'b0, '1);
    add_cfg(REG_INITIAL_PAGES, 32'd2);
    add_req(1'b1, REQ_LOAD, 32'd65528, 2'd3, 64'd0, 32'd0, 64'd0, 1'b0, 18'd0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        settle();
        write_register(directed_rows[r].reg_sel, directed_rows[r].reg_val);
      end else begin
        issue(directed_rows[r].rq, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          write_register(REG_INITIAL_PAGES, 32'd1);
          write_register(REG_HAS_MAX_LIMIT, 32'd0);
          write_register(REG_MAX_PAGES, 32'd65536);
        end
        1: begin
          write_register(REG_INITIAL_PAGES, 32'd0);
          write_register(REG_HAS_MAX_LIMIT, 32'd0);
          write_register(REG_MAX_PAGES, 32'd65536);
        end
        2: begin
          write_register(REG_INITIAL_PAGES, 32'd0);
          write_register(REG_HAS_MAX_LIMIT, 32'd1);
          write_register(REG_MAX_PAGES, 32'd0);
        end
        3: begin
          write_register(REG_INITIAL_PAGES, 32'd65536);
          write_register(REG_HAS_MAX_LIMIT, 32'd1);
          write_register(REG_MAX_PAGES, 32'd65536);
        end
        4: begin
          write_register(REG_INITIAL_PAGES, 32'd1);
          write_register(REG_HAS_MAX_LIMIT, 32'd1);
          write_register(REG_MAX_PAGES, 32'd0);
        end
        5: begin
          write_register(REG_INITIAL_PAGES, 32'd2);
          write_register(REG_HAS_MAX_LIMIT, 32'd0);
          write_register(REG_MAX_PAGES, 32'd1);
        end
        default: begin
          write_register(REG_INITIAL_PAGES, 32'd0);
          write_register(REG_HAS_MAX_LIMIT, 32'd1);
          write_register(REG_MAX_PAGES, 32'd1);
        end
      endcase
      n_settings++;
      quiet = (ph % 3 == 1);
      burst_left = $urandom_range(1, 24);
      pressure_at = $urandom_range(20, PHASE_ITEMS - 20);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        rq = random_request();
        issue(rq, 1'b0, '0);
        if (k == pressure_at) begin
          settle();
        end else if (!quiet) begin
          burst_left--;
          if (burst_left <= 0) begin
            pause_sender($urandom_range(1, 12));
            burst_left = $urandom_range(1, 24);
          end
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("covered %0d loads, %0d stores (%0d trapped), %0d grows (%0d refused), %0d unused",
             n_load, n_store, n_trap, n_grow, n_grow_refused, n_unused);
    $display("%0d register settings, %0d responses checked, %0d mismatches",
             n_settings + 1, responses_checked, mismatches);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
